// ===== rtl/core/sbda_pkg.sv =====
`timescale 1ns / 1ps

package sbda_pkg;

	// Width of the value being printed.
	localparam int VALUE_BITS = 32;

	// Width of the input field.
	localparam int IN_FIELD_BITS = 32;

	// Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
	// 77/256 is a little below log10(2).
	localparam int DIGITS = (VALUE_BITS * 77) / 256 + 1;
	localparam int BCD_W = 4 * DIGITS;

	// Counter widths.
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(DIGITS + 1);

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Characters.
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	// One classified word: sign and unsigned magnitude.
	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} entry_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== rtl/core/sbda_front.sv =====
`timescale 1ns / 1ps

module sbda_front (
	input  logic                                      start,
	input  logic signed [sbda_pkg::IN_FIELD_BITS-1:0] number,
	input  sbda_pkg::queue_status_t                   qstat,
	output logic                                      busy,
	output logic                                      push,
	output sbda_pkg::entry_t                          push_data
);
	import sbda_pkg::*;

	logic signed [63:0]     ext;
	logic [VALUE_BITS-1:0]  val;
	logic                   neg;

	// A word is taken whenever the queue has room.
	assign busy = qstat.full;
	assign push = start && !qstat.full;

	// Sign-extend the field, then wrap it to the value width.
	assign ext = 64'(number);
	assign val = ext[VALUE_BITS-1:0];
	assign neg = val[VALUE_BITS-1];

	// The magnitude is unsigned, so the most negative value needs no special path.
	assign push_data.neg = neg;
	assign push_data.mag = neg ? (~val + VALUE_BITS'(1)) : val;

endmodule

// ===== rtl/core/sbda_queue.sv =====
`timescale 1ns / 1ps

module sbda_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sbda_pkg::entry_t        push_data,
	input  logic                    pop,
	output sbda_pkg::entry_t        pop_data,
	output sbda_pkg::queue_status_t qstat
);
	import sbda_pkg::*;

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop  = pop && !qstat.empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/sbda_back.sv =====
`timescale 1ns / 1ps

module sbda_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sbda_pkg::queue_status_t qstat,
	input  sbda_pkg::entry_t        pop_data,
	output logic                    pop,
	output logic                    strobe,
	output logic [7:0]              text_char,
	output logic                    last_char
);
	import sbda_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_BITS - 1);

	logic [2:0]             state_q;
	logic [VALUE_BITS-1:0]  mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic                   neg_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   remain_q;
	logic                   strobe_q;
	logic [7:0]             text_char_q;
	logic                   last_char_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [3:0]             top_digit;

	assign pop = (state_q == ST_IDLE) && !qstat.empty;
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		bcd_adj = bcd_q;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end
		end
	end

	// Conversion and emission sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe_q  <= 1'b0;
			bit_cnt_q <= '0;
			remain_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						bit_cnt_q <= '0;
						remain_q  <= DIG_CNT_W'(DIGITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BIT_LAST) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Drop leading zeros, keeping at least one digit.
					if (top_digit == 4'd0 && remain_q != DIG_CNT_W'(1)) begin
						remain_q <= remain_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					remain_q <= remain_q - 1'b1;
					if (remain_q == DIG_CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: magnitude and BCD shift registers, result word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q <= pop_data.mag;
				neg_q <= pop_data.neg;
				bcd_q <= '0;
			end
			ST_CONV: begin
				{bcd_q, mag_q} <= {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && remain_q != DIG_CNT_W'(1)) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			ST_SIGN: begin
				text_char_q <= CHAR_MINUS;
				last_char_q <= 1'b0;
			end
			ST_EMIT: begin
				text_char_q <= CHAR_ZERO + {4'd0, top_digit};
				last_char_q <= (remain_q == DIG_CNT_W'(1));
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			default: begin
			end
		endcase
	end

	assign strobe    = strobe_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Each number goes through the serial double-dabble loop (one magnitude bit per cycle),
// then the one-digit-per-cycle scan and emission; the next word waits in the queue.
// Two words queue up ahead of the converter; busy rises while the queue is full.
// The receiver cannot stall: each character is shown for one cycle with strobe high.
// Reset clears the queue and the sequencer; no character is pending after reset.

module signed_binary_to_decimal_ascii (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [sbda_pkg::IN_FIELD_BITS-1:0] number,
	output logic                                      strobe,
	output logic [7:0]                                text_char,
	output logic                                      last_char
);
	import sbda_pkg::*;

	queue_status_t qstat;
	entry_t        push_data;
	entry_t        pop_data;
	logic          push;
	logic          pop;

	// Front: takes words and forms sign and magnitude.
	sbda_front u_front (
		.start     (start),
		.number    (number),
		.qstat     (qstat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// Short queue between front and back.
	sbda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// Back: converts to decimal and emits the characters.
	sbda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.strobe    (strobe),
		.text_char (text_char),
		.last_char (last_char)
	);

endmodule
